// ===== sv/rrp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types, constants and the quarter-wave sine table for the point
// rotation and reflection unit.
// ----------------------------------------------------------------------------
package rrp_pkg;

    localparam int ANGLE_W     = 16;
    localparam int MAT_W       = 18;
    localparam int TAB_W       = 17;
    localparam int IDX_W       = 7;
    localparam int U_W         = 17;
    localparam int Q_W         = 8;
    localparam int R_W         = 9;
    localparam int FRAC_BITS   = 16;
    localparam int RECIP_SHIFT = 25;
    localparam int CFG_IDX_W   = 3;

    localparam logic [R_W-1:0]   QUARTER_TURN = 9'd90;
    localparam logic [R_W-1:0]   HALF_TURN    = 9'd180;
    localparam logic [R_W-1:0]   THREE_QUARTER = 9'd270;
    localparam logic [R_W-1:0]   FULL_TURN    = 9'd360;
    // multiple of 360 that lifts any 16-bit signed angle above zero
    localparam logic [U_W-1:0]   ANGLE_BIAS   = 17'd33120;
    // ceil(2^25 / 360)
    localparam logic [U_W-1:0]   RECIP_360    = 17'd93207;
    localparam logic [TAB_W-1:0] ROUND_HALF   = 17'd32768;

    // quadrants whose sine and cosine are negative
    localparam logic [3:0] SIN_NEG = 4'b1100;
    localparam logic [3:0] COS_NEG = 4'b0110;

    localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd4;

    typedef logic signed [MAT_W-1:0] mat_elem_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] rotation_degrees;
        logic                      reflect_x;
        logic                      reflect_y;
    } rrp_angle_cfg_t;

    typedef struct packed {
        mat_elem_t m11;
        mat_elem_t m12;
        mat_elem_t m21;
        mat_elem_t m22;
    } rrp_matrix_t;

    localparam logic [TAB_W-1:0] QUARTER_SINE [0:90] = '{
        17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,
        17'd5712,  17'd6850,  17'd7987,  17'd9121,  17'd10252,
        17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
        17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336,
        17'd22415, 17'd23486, 17'd24550, 17'd25607, 17'd26656,
        17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772,
        17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
        17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243,
        17'd42126, 17'd42995, 17'd43852, 17'd44695, 17'd45525,
        17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
        17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020,
        17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175,
        17'd56756, 17'd57319, 17'd57865, 17'd58393, 17'd58903,
        17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
        17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997,
        17'd63303, 17'd63589, 17'd63856, 17'd64104, 17'd64332,
        17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
        17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526,
        17'd65536
    };

    function automatic logic [TAB_W-1:0] quarter_sine(input logic [IDX_W-1:0] idx);
        logic [TAB_W-1:0] val;
        val = '0;
        if (idx <= IDX_W'(QUARTER_TURN))
        begin
            val = QUARTER_SINE[idx];
        end
        return val;
    endfunction

endpackage

// ===== sv/rrp_in_if.sv =====
// ----------------------------------------------------------------------------
// rrp_in_if
// Point input channel: valid/ready handshake with point payload.
// ----------------------------------------------------------------------------
interface rrp_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// ===== sv/rrp_out_if.sv =====
// ----------------------------------------------------------------------------
// rrp_out_if
// Result output channel: valid/ready handshake with transformed point.
// ----------------------------------------------------------------------------
interface rrp_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] result_x;
    logic signed [COORD_WIDTH-1:0] result_y;
    logic                          result_last;

    modport source (output valid, output result_x, output result_y, output result_last,
                    input ready);
    modport sink (input valid, input result_x, input result_y, input result_last,
                  output ready);
endinterface

// ===== sv/rrp_matrix.sv =====
// ----------------------------------------------------------------------------
// rrp_matrix
// Three-stage angle reduction, quarter-wave lookup and matrix build.
// ----------------------------------------------------------------------------
module rrp_matrix (
    input  logic                    clk,
    input  logic                    en,
    input  rrp_pkg::rrp_angle_cfg_t cfg,
    output rrp_pkg::rrp_matrix_t    mat
);
    import rrp_pkg::*;

    logic signed [U_W-1:0]     angle_ext;
    logic [U_W-1:0]            biased;
    logic [2*U_W-1:0]          recip_prod;
    logic [U_W-1:0]            u_reg;
    logic [Q_W-1:0]            q_reg;
    logic [U_W-1:0]            rem_full;
    logic [R_W-1:0]            rem;
    logic [1:0]                quad_next;
    logic [R_W-1:0]            idx_full;
    logic [1:0]                quad_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [TAB_W-1:0]          s_mag;
    logic [TAB_W-1:0]          c_mag;
    mat_elem_t                 s_val;
    mat_elem_t                 c_val;
    rrp_matrix_t               mat_next;
    rrp_matrix_t               mat_reg;

    // stage 1: floor modulo via reciprocal multiply
    assign angle_ext  = {cfg.rotation_degrees[ANGLE_W-1], cfg.rotation_degrees};
    assign biased     = $unsigned(angle_ext) + ANGLE_BIAS;
    assign recip_prod = (2*U_W)'(biased) * (2*U_W)'(RECIP_360);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= biased;
            q_reg <= recip_prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        end
    end

    // stage 2: remainder and quadrant fold
    assign rem_full = u_reg - U_W'(U_W'(q_reg) * U_W'(FULL_TURN));
    assign rem      = rem_full[R_W-1:0];

    always_comb
    begin
        if (rem >= THREE_QUARTER)
        begin
            quad_next = 2'd3;
            idx_full  = FULL_TURN - rem;
        end
        else if (rem >= HALF_TURN)
        begin
            quad_next = 2'd2;
            idx_full  = rem - HALF_TURN;
        end
        else if (rem >= QUARTER_TURN)
        begin
            quad_next = 2'd1;
            idx_full  = HALF_TURN - rem;
        end
        else
        begin
            quad_next = 2'd0;
            idx_full  = rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg <= quad_next;
            idx_reg  <= idx_full[IDX_W-1:0];
        end
    end

    // stage 3: table lookup, signs and reflection
    assign s_mag = quarter_sine(idx_reg);
    assign c_mag = quarter_sine(IDX_W'(QUARTER_TURN) - idx_reg);
    assign s_val = SIN_NEG[quad_reg] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    assign c_val = COS_NEG[quad_reg] ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});

    always_comb
    begin
        mat_next.m11 = cfg.reflect_y ? -c_val : c_val;
        mat_next.m12 = cfg.reflect_y ? -s_val : s_val;
        mat_next.m21 = cfg.reflect_x ? s_val : -s_val;
        mat_next.m22 = cfg.reflect_x ? -c_val : c_val;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

// ===== sv/rrp_mac.sv =====
// ----------------------------------------------------------------------------
// rrp_mac
// Registered matrix products, then rounding, center offset and saturation.
// ----------------------------------------------------------------------------
module rrp_mac #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH:0]   dx,
    input  logic signed [COORD_WIDTH:0]   dy,
    input  rrp_pkg::rrp_matrix_t          mat,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    output logic signed [COORD_WIDTH-1:0] result_x,
    output logic signed [COORD_WIDTH-1:0] result_y
);
    import rrp_pkg::*;

    localparam int P_W = COORD_WIDTH + 1 + MAT_W;
    localparam int S_W = P_W + 1;
    localparam int H_W = S_W - FRAC_BITS;
    localparam int T_W = H_W + 1;

    logic signed [P_W-1:0] px0_reg;
    logic signed [P_W-1:0] px1_reg;
    logic signed [P_W-1:0] py0_reg;
    logic signed [P_W-1:0] py1_reg;

    function automatic logic [COORD_WIDTH-1:0] finish(
        input logic signed [P_W-1:0]         p0,
        input logic signed [P_W-1:0]         p1,
        input logic signed [COORD_WIDTH-1:0] center
    );
        logic signed [S_W-1:0] sum;
        logic signed [H_W-1:0] whole;
        logic signed [T_W-1:0] total;
        logic [COORD_WIDTH-1:0] res;
        sum   = S_W'(p0) + S_W'(p1) + $signed(S_W'(ROUND_HALF));
        whole = sum[S_W-1:FRAC_BITS];
        total = T_W'(whole) + T_W'(center);
        if (!total[T_W-1] && (|total[T_W-2:COORD_WIDTH-1]))
        begin
            res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        else if (total[T_W-1] && !(&total[T_W-2:COORD_WIDTH-1]))
        begin
            res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            res = total[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px0_reg <= dx * mat.m11;
            px1_reg <= dy * mat.m21;
            py0_reg <= dx * mat.m12;
            py1_reg <= dy * mat.m22;
        end
    end

    assign result_x = $signed(finish(px0_reg, px1_reg, center_x));
    assign result_y = $signed(finish(py0_reg, py1_reg, center_y));

endmodule

// ===== sv/rotate_reflect_points_unit.sv =====
// ----------------------------------------------------------------------------
// rotate_reflect_points_unit
// Rotates points about a center by a whole-degree angle with optional
// reflection, rounding products to nearest and saturating the results.
//
//   channel   dir  handshake        payload
//   pt_in     in   valid/ready      point_x, point_y, last_point
//   pt_out    out  valid/ready      result_x, result_y, result_last
//   cfg       in   cfg_write_en     cfg_index, cfg_data
//
// One point per cycle sustained unless a waiting result stalls the pipeline.
// A point passes the input, center-offset, delay, product and output registers.
// Reset clears configuration registers and all stage valid flags.
// A stalled result freezes the whole pipeline; ready is low only while a
// result waits and pt_out.ready is low.
// ----------------------------------------------------------------------------
module rotate_reflect_points_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [rrp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [((COORD_WIDTH > 16) ? COORD_WIDTH : 16)-1:0] cfg_data,
    rrp_in_if.sink                                pt_in,
    rrp_out_if.source                             pt_out
);
    import rrp_pkg::*;

    localparam int STAGES = 5;

    logic signed [ANGLE_W-1:0]     rotation_reg;
    logic                          reflect_x_reg;
    logic                          reflect_y_reg;
    logic signed [COORD_WIDTH-1:0] center_x_reg;
    logic signed [COORD_WIDTH-1:0] center_y_reg;

    logic                          adv;
    logic [STAGES-1:0]             valid_reg;
    logic [STAGES-1:0]             last_reg;
    logic signed [COORD_WIDTH-1:0] px_reg;
    logic signed [COORD_WIDTH-1:0] py_reg;
    logic signed [COORD_WIDTH:0]   dx1_reg;
    logic signed [COORD_WIDTH:0]   dy1_reg;
    logic signed [COORD_WIDTH:0]   dx2_reg;
    logic signed [COORD_WIDTH:0]   dy2_reg;
    logic signed [COORD_WIDTH:0]   dx3_reg;
    logic signed [COORD_WIDTH:0]   dy3_reg;
    rrp_angle_cfg_t                angle_cfg;
    rrp_matrix_t                   mat;
    logic signed [COORD_WIDTH-1:0] mac_x;
    logic signed [COORD_WIDTH-1:0] mac_y;
    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] result_x_reg;
    logic signed [COORD_WIDTH-1:0] result_y_reg;
    logic                          result_last_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg  <= '0;
            reflect_x_reg <= 1'b0;
            reflect_y_reg <= 1'b0;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_ROTATION:  rotation_reg  <= $signed(cfg_data[ANGLE_W-1:0]);
                REG_REFLECT_X: reflect_x_reg <= cfg_data[0];
                REG_REFLECT_Y: reflect_y_reg <= cfg_data[0];
                REG_CENTER_X:  center_x_reg  <= $signed(cfg_data[COORD_WIDTH-1:0]);
                REG_CENTER_Y:  center_y_reg  <= $signed(cfg_data[COORD_WIDTH-1:0]);
                default:       ;
            endcase
        end
    end

    assign adv          = !out_valid_reg || pt_out.ready;
    assign pt_in.ready  = adv;

    // valid and last flags move with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg     <= {valid_reg[STAGES-2:0], pt_in.valid};
            out_valid_reg <= valid_reg[STAGES-1];
        end
    end

    // point datapath
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg        <= {last_reg[STAGES-2:0], pt_in.last_point};
            px_reg          <= pt_in.point_x;
            py_reg          <= pt_in.point_y;
            dx1_reg         <= (COORD_WIDTH+1)'(px_reg) - (COORD_WIDTH+1)'(center_x_reg);
            dy1_reg         <= (COORD_WIDTH+1)'(py_reg) - (COORD_WIDTH+1)'(center_y_reg);
            dx2_reg         <= dx1_reg;
            dy2_reg         <= dy1_reg;
            dx3_reg         <= dx2_reg;
            dy3_reg         <= dy2_reg;
            result_x_reg    <= mac_x;
            result_y_reg    <= mac_y;
            result_last_reg <= last_reg[STAGES-1];
        end
    end

    always_comb
    begin
        angle_cfg.rotation_degrees = rotation_reg;
        angle_cfg.reflect_x        = reflect_x_reg;
        angle_cfg.reflect_y        = reflect_y_reg;
    end

    rrp_matrix u_matrix (
        .clk (clk),
        .en  (adv),
        .cfg (angle_cfg),
        .mat (mat)
    );

    rrp_mac #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_mac (
        .clk      (clk),
        .en       (adv),
        .dx       (dx3_reg),
        .dy       (dy3_reg),
        .mat      (mat),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .result_x (mac_x),
        .result_y (mac_y)
    );

    assign pt_out.valid       = out_valid_reg;
    assign pt_out.result_x    = result_x_reg;
    assign pt_out.result_y    = result_y_reg;
    assign pt_out.result_last = result_last_reg;

endmodule
